// ===== src/ill_pkg.sv =====
// Shared types and codes for the indexed linked list engine.
// No dependencies.
`timescale 1ns / 1ps
package ill_pkg;
    localparam int REQ_WIDTH = 3;
    localparam int ID_WIDTH  = 11;
    localparam int CFG_WIDTH = 11;
    localparam int SUM_WIDTH = 20;

    localparam logic [REQ_WIDTH-1:0] REQ_INIT    = 3'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_BEFORE  = 3'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_AFTER   = 3'd2;
    localparam logic [REQ_WIDTH-1:0] REQ_SWAP    = 3'd3;
    localparam logic [REQ_WIDTH-1:0] REQ_REVERSE = 3'd4;
    localparam logic [REQ_WIDTH-1:0] REQ_QUERY   = 3'd5;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 11'd1024;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] odd_sum;
        logic                 sum_valid;
        logic                 rejected;
    } t_result;
endpackage

// ===== src/ill_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ill_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1026
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/indexed_linked_list_engine.sv =====
// Top level: request sequencer over next/prev link RAMs.
// Depends on ill_pkg and ill_ram.
`timescale 1ns / 1ps
//  channel  | signals                                         | handshake
//  request  | i_req_type, i_first_box, i_second_box           | start & !busy
//  result   | o_odd_sum, o_sum_valid, o_rejected              | o_result_strobe, 1 cycle
//  config   | i_cfg_item_count                                | i_cfg_valid & o_cfg_ready
//
// Reject and reverse strobe their result straight from idle. Move/swap: links
// are read, a plan is made, then the link pairs (0, 3 or 4) are written, one pair
// per cycle across both RAMs. Init: the N nodes, N the saturated item count, plus
// head and tail, one node written per cycle. Query: one link RAM read per step.
// Synchronous active-low reset; link RAMs are not cleared. Results cannot be
// stalled; the strobe comes in the first cycle with busy low.
module indexed_linked_list_engine #(
    parameter int MAX_ITEMS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ill_pkg::REQ_WIDTH-1:0] i_req_type,
    input  logic [ill_pkg::ID_WIDTH-1:0]  i_first_box,
    input  logic [ill_pkg::ID_WIDTH-1:0]  i_second_box,
    output logic                          o_result_strobe,
    output logic [ill_pkg::SUM_WIDTH-1:0] o_odd_sum,
    output logic                          o_sum_valid,
    output logic                          o_rejected,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ill_pkg::CFG_WIDTH-1:0] i_cfg_item_count
);
    localparam int NODES = MAX_ITEMS + 2;
    localparam int NW    = $clog2(NODES);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam logic [NW-1:0] HEAD_NODE = '0;
    localparam logic [NW-1:0] TAIL_NODE = NW'(MAX_ITEMS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_ITAIL = 3'd2;
    localparam logic [2:0] S_QDAT  = 3'd3;
    localparam logic [2:0] S_RDY   = 3'd4;
    localparam logic [2:0] S_PLAN  = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;

    logic [2:0]                      r_state, n_state;
    logic [ill_pkg::CFG_WIDTH-1:0]   r_cfg;
    logic                            r_ready, n_ready;
    logic                            r_rev, n_rev;
    logic [CW-1:0]                   r_active, n_active;
    logic [NW-1:0]                   r_i, n_i;
    logic [NW-1:0]                   r_x, n_x, r_y, n_y;
    logic [ill_pkg::REQ_WIDTH-1:0]   r_op, n_op;
    logic [NW-1:0]                   r_px, n_px, r_nx, n_nx;
    logic [NW-1:0]                   r_pa [4];
    logic [NW-1:0]                   r_pb [4];
    logic [NW-1:0]                   n_pa [4];
    logic [NW-1:0]                   n_pb [4];
    logic [2:0]                      r_pcnt, n_pcnt;
    logic [1:0]                      r_pidx, n_pidx;
    logic [ill_pkg::SUM_WIDTH-1:0]   r_sum, n_sum;
    logic [CW-1:0]                   r_steps, n_steps;
    logic                            r_odd, n_odd;
    logic                            r_strobe, n_strobe;
    ill_pkg::t_result                r_res, n_res;

    logic          nx_we, pv_we;
    logic [NW-1:0] nx_waddr, pv_waddr, nx_wdata, pv_wdata, raddr;
    logic [NW-1:0] nx_rdata, pv_rdata, walk_node;
    logic          accept, bad_ids;
    logic [CW-1:0] init_n;

    ill_ram #(.WIDTH(NW), .DEPTH(NODES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(raddr), .o_rdata(nx_rdata)
    );
    ill_ram #(.WIDTH(NW), .DEPTH(NODES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(raddr), .o_rdata(pv_rdata)
    );

    assign busy            = (r_state != S_IDLE);
    assign accept          = start && !busy;
    assign o_cfg_ready     = 1'b1;
    assign o_result_strobe = r_strobe;
    assign o_odd_sum       = r_res.odd_sum;
    assign o_sum_valid     = r_res.sum_valid;
    assign o_rejected      = r_res.rejected;
    assign walk_node       = r_rev ? pv_rdata : nx_rdata;
    assign init_n = (32'(r_cfg) > MAX_ITEMS) ? CW'(MAX_ITEMS) : CW'(r_cfg);
    assign bad_ids = (i_first_box == '0) || (i_second_box == '0) ||
                     (32'(i_first_box) > 32'(r_active)) ||
                     (32'(i_second_box) > 32'(r_active)) ||
                     (i_first_box == i_second_box);

    always_comb begin
        n_state  = r_state;
        n_ready  = r_ready;
        n_rev    = r_rev;
        n_active = r_active;
        n_i      = r_i;
        n_x      = r_x;
        n_y      = r_y;
        n_op     = r_op;
        n_px     = r_px;
        n_nx     = r_nx;
        n_pa     = r_pa;
        n_pb     = r_pb;
        n_pcnt   = r_pcnt;
        n_pidx   = r_pidx;
        n_sum    = r_sum;
        n_steps  = r_steps;
        n_odd    = r_odd;
        n_strobe = 1'b0;
        n_res    = r_res;
        nx_we    = 1'b0;
        pv_we    = 1'b0;
        nx_waddr = r_i;
        pv_waddr = r_i;
        nx_wdata = (r_i == NW'(r_active)) ? TAIL_NODE : r_i + 1'b1;
        pv_wdata = (r_i == HEAD_NODE) ? TAIL_NODE : r_i - 1'b1;
        raddr    = NW'(i_first_box);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    n_x   = NW'(i_first_box);
                    n_y   = NW'(i_second_box);
                    n_op  = i_req_type;
                    if (r_rev && i_req_type == ill_pkg::REQ_BEFORE) begin
                        n_op = ill_pkg::REQ_AFTER;
                    end else if (r_rev && i_req_type == ill_pkg::REQ_AFTER) begin
                        n_op = ill_pkg::REQ_BEFORE;
                    end
                    if (i_req_type == ill_pkg::REQ_INIT) begin
                        n_active = init_n;
                        n_rev    = 1'b0;
                        n_ready  = 1'b1;
                        n_i      = HEAD_NODE;
                        n_state  = S_INIT;
                    end else if (!r_ready || i_req_type > ill_pkg::REQ_QUERY) begin
                        n_res.rejected = 1'b1;
                        n_strobe       = 1'b1;
                    end else if (i_req_type == ill_pkg::REQ_REVERSE) begin
                        n_rev    = !r_rev;
                        n_strobe = 1'b1;
                    end else if (i_req_type == ill_pkg::REQ_QUERY) begin
                        raddr   = r_rev ? TAIL_NODE : HEAD_NODE;
                        n_sum   = '0;
                        n_steps = '0;
                        n_odd   = 1'b1;
                        n_state = S_QDAT;
                    end else if (bad_ids) begin
                        n_res.rejected = 1'b1;
                        n_strobe       = 1'b1;
                    end else begin
                        n_state = S_RDY;
                    end
                end
            end
            S_INIT: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
                n_i   = r_i + 1'b1;
                if (r_i == NW'(r_active)) begin
                    n_state = S_ITAIL;
                end
            end
            S_ITAIL: begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_waddr = TAIL_NODE;
                pv_waddr = TAIL_NODE;
                nx_wdata = HEAD_NODE;
                pv_wdata = NW'(r_active);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_QDAT: begin
                raddr = walk_node;
                if (walk_node == HEAD_NODE || walk_node == TAIL_NODE ||
                    r_steps == r_active) begin
                    n_res.odd_sum   = r_sum;
                    n_res.sum_valid = 1'b1;
                    n_strobe        = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    if (r_odd) begin
                        n_sum = r_sum + ill_pkg::SUM_WIDTH'(walk_node);
                    end
                    n_odd   = !r_odd;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_RDY: begin
                raddr   = r_y;
                n_px    = pv_rdata;
                n_nx    = nx_rdata;
                n_state = S_PLAN;
            end
            S_PLAN: begin
                n_pcnt = 3'd3;
                n_pidx = '0;
                case (r_op)
                    ill_pkg::REQ_BEFORE: begin
                        if (r_nx == r_y) n_pcnt = 3'd0;
                        n_pa[0] = r_px;     n_pb[0] = r_nx;
                        n_pa[1] = pv_rdata; n_pb[1] = r_x;
                        n_pa[2] = r_x;      n_pb[2] = r_y;
                    end
                    ill_pkg::REQ_AFTER: begin
                        if (nx_rdata == r_x) n_pcnt = 3'd0;
                        n_pa[0] = r_px; n_pb[0] = r_nx;
                        n_pa[1] = r_y;  n_pb[1] = r_x;
                        n_pa[2] = r_x;  n_pb[2] = nx_rdata;
                    end
                    default: begin
                        if (r_nx == r_y) begin
                            n_pa[0] = r_px; n_pb[0] = r_y;
                            n_pa[1] = r_y;  n_pb[1] = r_x;
                            n_pa[2] = r_x;  n_pb[2] = nx_rdata;
                        end else if (nx_rdata == r_x) begin
                            n_pa[0] = pv_rdata; n_pb[0] = r_x;
                            n_pa[1] = r_x;      n_pb[1] = r_y;
                            n_pa[2] = r_y;      n_pb[2] = r_nx;
                        end else begin
                            n_pcnt  = 3'd4;
                            n_pa[0] = r_px;     n_pb[0] = r_y;
                            n_pa[1] = r_y;      n_pb[1] = r_nx;
                            n_pa[2] = pv_rdata; n_pb[2] = r_x;
                            n_pa[3] = r_x;      n_pb[3] = nx_rdata;
                        end
                    end
                endcase
                if (n_pcnt == 3'd0) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_waddr = r_pa[r_pidx];
                nx_wdata = r_pb[r_pidx];
                pv_waddr = r_pb[r_pidx];
                pv_wdata = r_pa[r_pidx];
                n_pidx   = r_pidx + 1'b1;
                if ({1'b0, r_pidx} == r_pcnt - 1'b1) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= ill_pkg::CFG_RESET;
            r_ready  <= 1'b0;
            r_rev    <= 1'b0;
            r_active <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ready  <= n_ready;
            r_rev    <= n_rev;
            r_active <= n_active;
            r_strobe <= n_strobe;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_item_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_x     <= n_x;
        r_y     <= n_y;
        r_op    <= n_op;
        r_px    <= n_px;
        r_nx    <= n_nx;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        r_pcnt  <= n_pcnt;
        r_pidx  <= n_pidx;
        r_sum   <= n_sum;
        r_steps <= n_steps;
        r_odd   <= n_odd;
        r_res   <= n_res;
    end

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while busy");
    a_sum_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.sum_valid) |-> !r_res.rejected)
        else $error("query answer flagged rejected");
    a_reverse_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_ready && i_req_type == ill_pkg::REQ_REVERSE)
            |=> (r_strobe && r_rev != $past(r_rev)))
        else $error("reverse did not complete in one cycle");
    a_write_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ({1'b0, r_pidx} < r_pcnt))
        else $error("link pair index beyond plan");
endmodule

// ===== tb/tb_indexed_linked_list_engine.sv =====
// Testbench for indexed_linked_list_engine: queue-fed driver, strobe monitor,
// and an in-bench list predictor. Depends on ill_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_indexed_linked_list_engine;
    localparam int MAX_ITEMS = 1024;
    localparam int TAIL = MAX_ITEMS + 1;
    localparam int RQW  = ill_pkg::REQ_WIDTH;
    localparam int IDW  = ill_pkg::ID_WIDTH;
    localparam int SMW  = ill_pkg::SUM_WIDTH;
    localparam int CFW  = ill_pkg::CFG_WIDTH;
    localparam logic [RQW-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [RQW-1:0] REQ_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [RQW-1:0] req;
        logic [IDW-1:0] x;
        logic [IDW-1:0] y;
    } t_request;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic [RQW-1:0] i_req_type = '0;
    logic [IDW-1:0] i_first_box = '0;
    logic [IDW-1:0] i_second_box = '0;
    logic           o_result_strobe;
    logic [SMW-1:0] o_odd_sum;
    logic           o_sum_valid;
    logic           o_rejected;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [CFW-1:0] i_cfg_item_count = '0;

    indexed_linked_list_engine #(.MAX_ITEMS(MAX_ITEMS)) DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // list mirror
    logic [IDW-1:0] nxt [0:MAX_ITEMS+1];
    logic [IDW-1:0] prv [0:MAX_ITEMS+1];
    logic           reversed_m = 1'b0;
    logic           ready_m = 1'b0;
    int             active_m = 0;
    logic [CFW-1:0] count_reg = ill_pkg::CFG_RESET;

    t_request         pending_requests[$];
    ill_pkg::t_result expected_results[$];
    int               errors = 0;
    int               idle_pct = 0;
    logic             taken = 1'b0;

    function automatic void link(int a, int b);
        nxt[a] = IDW'(b);
        prv[b] = IDW'(a);
    endfunction

    function automatic void place_after(int at, int n);
        int after;
        after = nxt[at];
        link(at, n);
        link(n, after);
    endfunction

    function automatic void place_before(int n, int at);
        int bef;
        bef = prv[at];
        link(bef, n);
        link(n, at);
    endfunction

    function automatic void swap_linked_pair(int a, int b);
        int l, r;
        l = prv[a];
        r = nxt[b];
        link(l, b);
        link(b, a);
        link(a, r);
    endfunction

    function automatic logic [SMW-1:0] odd_sum_of_order();
        logic [SMW-1:0] s;
        int node, pos;
        s = '0;
        pos = 1;
        node = reversed_m ? prv[TAIL] : nxt[0];
        while (node != 0 && node != TAIL && pos <= active_m) begin
            if (pos % 2 == 1) s = s + node[SMW-1:0];
            pos++;
            node = reversed_m ? prv[node] : nxt[node];
        end
        return s;
    endfunction

    function automatic ill_pkg::t_result apply_request(t_request t);
        ill_pkg::t_result r;
        logic [RQW-1:0] op;
        int x, y, n, pa, pb;
        r = '0;
        op = t.req;
        x = t.x;
        y = t.y;
        if (op == ill_pkg::REQ_INIT) begin
            n = (count_reg > MAX_ITEMS) ? MAX_ITEMS : count_reg;
            link(0, TAIL);
            prv[0] = IDW'(TAIL);
            nxt[TAIL] = '0;
            for (int i = 1; i <= n; i++) place_before(i, TAIL);
            active_m = n;
            reversed_m = 1'b0;
            ready_m = 1'b1;
        end else if (!ready_m || op == REQ_UNUSED_LO || op == REQ_UNUSED_HI) begin
            r.rejected = 1'b1;
        end else if (op == ill_pkg::REQ_REVERSE) begin
            reversed_m = !reversed_m;
        end else if (op == ill_pkg::REQ_QUERY) begin
            r.odd_sum = odd_sum_of_order();
            r.sum_valid = 1'b1;
        end else if (x == 0 || y == 0 || x > active_m || y > active_m || x == y) begin
            r.rejected = 1'b1;
        end else begin
            if (reversed_m && op != ill_pkg::REQ_SWAP)
                op = (op == ill_pkg::REQ_BEFORE) ? ill_pkg::REQ_AFTER : ill_pkg::REQ_BEFORE;
            if (op == ill_pkg::REQ_BEFORE) begin
                if (nxt[x] != y) begin
                    link(prv[x], nxt[x]);
                    place_before(x, y);
                end
            end else if (op == ill_pkg::REQ_AFTER) begin
                if (nxt[y] != x) begin
                    link(prv[x], nxt[x]);
                    place_after(y, x);
                end
            end else if (nxt[x] == y) begin
                swap_linked_pair(x, y);
            end else if (nxt[y] == x) begin
                swap_linked_pair(y, x);
            end else begin
                pa = prv[x];
                pb = prv[y];
                link(prv[x], nxt[x]);
                link(prv[y], nxt[y]);
                place_after(pa, y);
                place_after(pb, x);
            end
        end
        return r;
    endfunction

    // accept + predict, and check results
    always @(posedge i_clk) begin
        taken <= start && !busy && i_rst_n;
        if (i_rst_n && start && !busy)
            expected_results = {expected_results,
                                apply_request({i_req_type, i_first_box, i_second_box})};
        if (i_rst_n && o_result_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result sum=%0d valid=%b rej=%b", $realtime,
                         o_odd_sum, o_sum_valid, o_rejected);
                errors++;
            end else begin
                ill_pkg::t_result e;
                e = expected_results.pop_front();
                if (e.odd_sum !== o_odd_sum || e.sum_valid !== o_sum_valid
                        || e.rejected !== o_rejected) begin
                    $display({"%0t: mismatch exp sum=%0d valid=%b rej=%b",
                              " act sum=%0d valid=%b rej=%b"},
                             $realtime, e.odd_sum, e.sum_valid, e.rejected,
                             o_odd_sum, o_sum_valid, o_rejected);
                    errors++;
                end
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || taken)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
                t_request t;
                t = pending_requests.pop_front();
                start <= 1'b1;
                i_req_type <= t.req;
                i_first_box <= t.x;
                i_second_box <= t.y;
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic void push_req(logic [RQW-1:0] op, int x, int y);
        t_request t;
        t.req = op;
        t.x = x[IDW-1:0];
        t.y = y[IDW-1:0];
        pending_requests = {pending_requests, t};
    endfunction

    function automatic void push_random(int n);
        int r;
        r = $urandom_range(99);
        if (r < 30) push_req(ill_pkg::REQ_BEFORE, $urandom_range(n, 1), $urandom_range(n, 1));
        else if (r < 58) push_req(ill_pkg::REQ_AFTER, $urandom_range(n, 1), $urandom_range(n, 1));
        else if (r < 78) push_req(ill_pkg::REQ_SWAP, $urandom_range(n, 1), $urandom_range(n, 1));
        else if (r < 86) push_req(ill_pkg::REQ_REVERSE, $urandom, $urandom);
        else if (r < 92) push_req(ill_pkg::REQ_QUERY, $urandom, $urandom);
        else if (r < 96) push_req(RQW'($urandom_range(7)), $urandom, $urandom);
        else if (r < 98) push_req(ill_pkg::REQ_SWAP, 0, n + 1);
        else push_req(ill_pkg::REQ_BEFORE, n, n);
    endfunction

    task automatic drain();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || start || expected_results.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CFW-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_item_count <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        count_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int n;
        int pcts[4] = '{0, 54, 0, 33};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        push_req(ill_pkg::REQ_QUERY, 0, 0);
        push_req(ill_pkg::REQ_BEFORE, 1, 2);
        push_req(ill_pkg::REQ_REVERSE, 0, 0);
        push_req(REQ_UNUSED_HI, 2047, 2047);
        push_req(ill_pkg::REQ_INIT, 0, 0);
        push_req(ill_pkg::REQ_QUERY, 0, 0);
        push_req(ill_pkg::REQ_BEFORE, 1024, 1);
        push_req(ill_pkg::REQ_AFTER, 1, 1024);
        push_req(ill_pkg::REQ_SWAP, 2, 3);
        push_req(ill_pkg::REQ_SWAP, 3, 2);
        push_req(ill_pkg::REQ_SWAP, 5, 900);
        push_req(ill_pkg::REQ_BEFORE, 6, 7);
        push_req(ill_pkg::REQ_REVERSE, 0, 0);
        push_req(ill_pkg::REQ_BEFORE, 10, 20);
        push_req(ill_pkg::REQ_AFTER, 30, 40);
        push_req(ill_pkg::REQ_BEFORE, 0, 5);
        push_req(ill_pkg::REQ_AFTER, 5, 1025);
        push_req(ill_pkg::REQ_SWAP, 2047, 1);
        push_req(ill_pkg::REQ_SWAP, 9, 9);
        push_req(REQ_UNUSED_LO, 1, 2);
        push_req(ill_pkg::REQ_QUERY, 2047, 2047);
        drain();
        write_count('0);
        push_req(ill_pkg::REQ_INIT, 0, 0);
        push_req(ill_pkg::REQ_BEFORE, 1, 2);
        push_req(ill_pkg::REQ_QUERY, 0, 0);
        drain();
        write_count(CFW'(2047));
        push_req(ill_pkg::REQ_INIT, 0, 0);
        push_req(ill_pkg::REQ_QUERY, 0, 0);
        drain();

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            idle_pct = pcts[ph % 4];
            if (ph == 5) n = 1024;
            else if (ph == 8) n = 1;
            else n = $urandom_range(16, 2);
            write_count(CFW'(n));
            push_req(ill_pkg::REQ_INIT, 0, 0);
            for (int k = 0; k < 105; k++) begin
                if ($urandom_range(99) < 2) push_req(ill_pkg::REQ_INIT, 0, 0);
                else push_random(n);
            end
            drain();
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
